@@ sv/tunnel_packet_deframer_core_defines.svh @@
// ---------------------------------------------------------------------------
// tunnel packet deframer assertion macros
// shared assertion forms for the deframer checker
// ---------------------------------------------------------------------------
`ifndef TUNNEL_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define TUNNEL_PACKET_DEFRAMER_CORE_DEFINES_SVH

// checked only outside reset
`define TPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tpd_pkg.sv @@
// ---------------------------------------------------------------------------
// tunnel packet deframer package
// shared types, codes and header layout constants
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int HEADER_BYTES = 17;
    localparam int HDR_IDX_W    = 5;

    // header layout, byte index of the last byte of each field
    localparam logic [HDR_IDX_W-1:0] SERVICE_IDX  = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] SESSION_LAST = HDR_IDX_W'(4);
    localparam logic [HDR_IDX_W-1:0] TRACK_LAST   = HDR_IDX_W'(8);
    localparam logic [HDR_IDX_W-1:0] LENGTH_LAST  = HDR_IDX_W'(12);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HEADER_BYTES - 1);

    localparam logic [7:0] VERSION_RESET = 8'd3;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_BADVER  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_HDR_BYTE = 2'd0,
        OP_PAY_BYTE = 2'd1,
        OP_BAD_VER  = 2'd2
    } t_op_code;

    // classified byte from the front end
    typedef struct packed {
        t_op_code               code;
        logic [HDR_IDX_W-1:0]   idx;
        logic [7:0]             data;
        logic                   last;
    } t_op;

    typedef struct packed {
        t_kind          kind;
        logic [7:0]     service_type;
        logic [31:0]    session_id;
        logic [31:0]    tracking_id;
        logic [31:0]    payload_length;
        logic [31:0]    header_check;
        logic [7:0]     payload_byte;
        logic           last;
    } t_result;

endpackage

@@ sv/tpd_fifo.sv @@
// ---------------------------------------------------------------------------
// tpd fifo
// small register queue with full and empty flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpd_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/tpd_front.sv @@
// ---------------------------------------------------------------------------
// tpd front end
// tracks packet phase and classifies each received byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    input  logic [7:0]     i_accepted_version,
    output logic           o_op_valid,
    output tpd_pkg::t_op   o_op
);

    typedef enum logic [1:0] {
        ST_VERSION,
        ST_HEADER,
        ST_PAYLOAD
    } t_state;

    t_state                         r_state, n_state;
    logic [tpd_pkg::HDR_IDX_W-1:0]  r_hdr_count, n_hdr_count;
    logic [31:0]                    r_length, n_length;
    logic [31:0]                    r_bytes_left, n_bytes_left;

    always_comb begin
        n_state      = r_state;
        n_hdr_count  = r_hdr_count;
        n_length     = r_length;
        n_bytes_left = r_bytes_left;
        o_op_valid   = 1'b0;
        o_op.code    = tpd_pkg::OP_BAD_VER;
        o_op.idx     = r_hdr_count;
        o_op.data    = i_rx_byte;
        o_op.last    = 1'b0;
        case (r_state)
            ST_HEADER: begin
                o_op_valid = i_accept;
                o_op.code  = tpd_pkg::OP_HDR_BYTE;
                o_op.last  = (r_length == '0);
                if (i_accept) begin
                    if (r_hdr_count > tpd_pkg::TRACK_LAST
                        && r_hdr_count <= tpd_pkg::LENGTH_LAST) begin
                        n_length = {r_length[23:0], i_rx_byte};
                    end
                    if (r_hdr_count == tpd_pkg::HDR_LAST_IDX) begin
                        n_hdr_count  = '0;
                        n_bytes_left = r_length;
                        n_state      = (r_length == '0) ? ST_VERSION : ST_PAYLOAD;
                    end else begin
                        n_hdr_count = r_hdr_count + 1'b1;
                    end
                end
            end
            ST_PAYLOAD: begin
                o_op_valid = i_accept;
                o_op.code  = tpd_pkg::OP_PAY_BYTE;
                o_op.last  = (r_bytes_left == 32'd1);
                if (i_accept) begin
                    n_bytes_left = r_bytes_left - 1'b1;
                    if (r_bytes_left == 32'd1) begin
                        n_state = ST_VERSION;
                    end
                end
            end
            default: begin
                // version match opens a header, anything else is reported
                if (i_rx_byte == i_accepted_version) begin
                    if (i_accept) begin
                        n_state     = ST_HEADER;
                        n_hdr_count = '0;
                    end
                end else begin
                    o_op_valid = i_accept;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_VERSION;
            r_hdr_count  <= '0;
            r_length     <= '0;
            r_bytes_left <= '0;
        end else begin
            r_state      <= n_state;
            r_hdr_count  <= n_hdr_count;
            r_length     <= n_length;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

@@ sv/tpd_back.sv @@
// ---------------------------------------------------------------------------
// tpd back end
// assembles header fields and builds result items
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpd_back (
    input  logic              i_clk,
    input  logic              i_take,
    input  tpd_pkg::t_op      i_op,
    output logic              o_res_valid,
    output tpd_pkg::t_result  o_res
);

    logic [7:0]  r_service;
    logic [31:0] r_session, r_tracking, r_length, r_check;
    logic [31:0] check_full;

    assign check_full = {r_check[23:0], i_op.data};

    always_ff @(posedge i_clk) begin
        if (i_take && i_op.code == tpd_pkg::OP_HDR_BYTE) begin
            if (i_op.idx == tpd_pkg::SERVICE_IDX) begin
                r_service <= i_op.data;
            end else if (i_op.idx <= tpd_pkg::SESSION_LAST) begin
                r_session <= {r_session[23:0], i_op.data};
            end else if (i_op.idx <= tpd_pkg::TRACK_LAST) begin
                r_tracking <= {r_tracking[23:0], i_op.data};
            end else if (i_op.idx <= tpd_pkg::LENGTH_LAST) begin
                r_length <= {r_length[23:0], i_op.data};
            end else begin
                r_check <= check_full;
            end
        end
    end

    always_comb begin
        o_res       = '0;
        o_res_valid = 1'b0;
        case (i_op.code)
            tpd_pkg::OP_HDR_BYTE: begin
                o_res_valid          = i_take && (i_op.idx == tpd_pkg::HDR_LAST_IDX);
                o_res.kind           = tpd_pkg::KIND_HEADER;
                o_res.service_type   = r_service;
                o_res.session_id     = r_session;
                o_res.tracking_id    = r_tracking;
                o_res.payload_length = r_length;
                o_res.header_check   = check_full;
                o_res.last           = i_op.last;
            end
            tpd_pkg::OP_PAY_BYTE: begin
                o_res_valid        = i_take;
                o_res.kind         = tpd_pkg::KIND_PAYLOAD;
                o_res.payload_byte = i_op.data;
                o_res.last         = i_op.last;
            end
            default: begin
                o_res_valid = i_take;
                o_res.kind  = tpd_pkg::KIND_BADVER;
            end
        endcase
    end

endmodule

@@ sv/tunnel_packet_deframer_core.sv @@
// ---------------------------------------------------------------------------
// tunnel packet deframer core
// length-prefixed packet deframer for a received byte stream
// ---------------------------------------------------------------------------
// Takes one byte per cycle, sustained, whenever full is low: nothing in the
// byte path loops, each byte needs one compare, one shift or one count
// update. A byte equal to the accepted version opens a packet and gives no
// result; the next 17 bytes form the header, which comes out as one result
// on its last byte, and then each payload byte comes out as a result of its
// own with last set on the final one (on the header when the length is
// zero). Any other byte while waiting for a version gives a bad-version
// result and is dropped. A result passes from the front end through the
// command queue to the back end and on into the output queue, whose head is
// shown on the result ports; the queue between the front and back ends and
// the output queue let either side stall on its own. The header check word
// is passed on unchecked. The accepted version may be rewritten only while
// the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tunnel_packet_deframer_core #(
    parameter int CMD_DEPTH = tpd_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = tpd_pkg::OUT_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data,
    // byte input queue side
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_service_type,
    output logic [31:0]        o_session_id,
    output logic signed [31:0] o_tracking_id,
    output logic [31:0]        o_payload_length,
    output logic [31:0]        o_header_check,
    output logic [7:0]         o_payload_byte,
    output logic               o_last
);

    localparam int OP_W  = $bits(tpd_pkg::t_op);
    localparam int RES_W = $bits(tpd_pkg::t_result);

    logic [7:0]        r_accepted_version;
    logic              accept;
    logic              op_valid;
    tpd_pkg::t_op      op_in, op_out;
    logic              cmd_full, cmd_empty;
    logic              take;
    logic              res_valid;
    tpd_pkg::t_result  res_in, res_out;
    logic              out_full;

    // the register is always ready to take a transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted_version <= tpd_pkg::VERSION_RESET;
        end else if (i_cfg_valid) begin
            r_accepted_version <= i_cfg_data;
        end
    end

    // input transfer happens when the command queue has room
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    tpd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_rx_byte          (i_rx_byte),
        .i_accepted_version (r_accepted_version),
        .o_op_valid         (op_valid),
        .o_op               (op_in)
    );

    // classified bytes between front and back ends
    tpd_fifo #(
        .DEPTH (CMD_DEPTH),
        .WIDTH (OP_W)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_valid),
        .i_data  (op_in),
        .o_full  (cmd_full),
        .i_pop   (take),
        .o_data  (op_out),
        .o_empty (cmd_empty)
    );

    // back end advances whenever a classified byte waits and the output queue has room
    assign take = !cmd_empty && !out_full;

    tpd_back u_back (
        .i_clk       (i_clk),
        .i_take      (take),
        .i_op        (op_out),
        .o_res_valid (res_valid),
        .o_res       (res_in)
    );

    // result queue, its head is shown on the output ports
    tpd_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RES_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_kind           = res_out.kind;
    assign o_service_type   = res_out.service_type;
    assign o_session_id     = res_out.session_id;
    assign o_tracking_id    = signed'(res_out.tracking_id);
    assign o_payload_length = res_out.payload_length;
    assign o_header_check   = res_out.header_check;
    assign o_payload_byte   = res_out.payload_byte;
    assign o_last           = res_out.last;

endmodule

@@ sv/tpd_checker.sv @@
// ---------------------------------------------------------------------------
// tpd checker
// port-level checks on the deframer result stream
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tunnel_packet_deframer_core_defines.svh"

module tpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [31:0] o_payload_length,
    input logic [7:0]  o_payload_byte,
    input logic        o_last
);

    `TPD_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !$past(i_rst_n) |-> empty, "results present after reset")
    `TPD_ASSERT(a_kind_code, i_clk, i_rst_n, !empty |-> (o_kind <= tpd_pkg::KIND_BADVER), "unknown result kind")
    `TPD_ASSERT(a_badver_clean, i_clk, i_rst_n, (!empty && o_kind == tpd_pkg::KIND_BADVER) |-> (!o_last && o_payload_length == '0 && o_payload_byte == '0), "bad version result carries data")
    `TPD_ASSERT(a_header_last, i_clk, i_rst_n, (!empty && o_kind == tpd_pkg::KIND_HEADER) |-> (o_last == (o_payload_length == '0)), "header last mark disagrees with length")
    `TPD_ASSERT(a_result_holds, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_last)), "waiting result changed")

endmodule

bind tunnel_packet_deframer_core tpd_checker u_tpd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_kind           (o_kind),
    .o_payload_length (o_payload_length),
    .o_payload_byte   (o_payload_byte),
    .o_last           (o_last)
);
